@@ design/ffha_pkg.sv @@
package ffha_pkg;
    localparam int MAX_BLOCKS   = 64;
    localparam int HEAP_BYTES   = 1024 * 1024;
    localparam int HEADER_BYTES = 16;
    localparam int IDX_W        = $clog2(MAX_BLOCKS);
    localparam int CNT_W        = $clog2(MAX_BLOCKS + 1);

    localparam logic       OP_ALLOC   = 1'b0;
    localparam logic       OP_FREE    = 1'b1;
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOFIT   = 2'd1;
    localparam logic [1:0] ST_BADFREE = 2'd2;

    localparam logic [19:0] HDR20      = 20'(HEADER_BYTES);
    localparam logic [19:0] INIT_PAY   = 20'(HEAP_BYTES - HEADER_BYTES);

    // table entry held by one cell
    typedef struct packed {
        logic [19:0] start;
        logic [19:0] payload;
        logic        is_free;
    } entry_t;

    // row-wide command applied by every cell in the same cycle
    typedef struct packed {
        logic        shift_up;    // split: cells above sel+1 take left neighbor
        logic        shift_down;  // merge: cells above sel take right neighbor
        logic        write_sel;   // cell sel gets wr_entry
        logic        write_next;  // cell sel+1 gets nx_entry
        logic [IDX_W-1:0] sel;
        entry_t      wr_entry;
        entry_t      nx_entry;
    } cmd_t;
endpackage

@@ design/ffha_cell.sv @@
module ffha_cell
    import ffha_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [IDX_W-1:0] my_idx,
    input  logic             reset_free,
    input  logic [19:0]      reset_payload,
    input  cmd_t             cmd,
    input  entry_t           left_in,
    input  entry_t           right_in,
    input  logic             top_valid,
    output entry_t           entry,
    // per-cell compare results
    input  logic [20:0]      req_size,
    input  logic [19:0]      addr,
    output logic             fit,
    output logic             hit
);
    entry_t entry_reg, entry_next;

    assign entry = entry_reg;
    assign fit = entry_reg.is_free && ({1'b0, entry_reg.payload} >= req_size);
    assign hit = (entry_reg.start + HDR20) == addr;

    // update from command
    always_comb
    begin
        entry_next = entry_reg;
        if (cmd.write_sel && my_idx == cmd.sel)
            entry_next = cmd.wr_entry;
        else if (cmd.write_next && my_idx == cmd.sel + IDX_W'(1))
            entry_next = cmd.nx_entry;
        else if (cmd.shift_up && my_idx > cmd.sel + IDX_W'(1))
            entry_next = left_in;
        else if (cmd.shift_down && my_idx > cmd.sel)
            entry_next = top_valid ? right_in : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            entry_reg <= '{start: 20'd0, payload: reset_payload, is_free: reset_free};
        else
            entry_reg <= entry_next;
    end
endmodule

@@ design/first_fit_heap_allocator_core.sv @@
// First-fit heap allocator core.
// Issue one item by raising start with op, req_size and payload_addr while
// busy is low. op 0 allocates req_size bytes, op 1 frees payload_addr.
// The table of blocks is a row of cells, one per entry, in address order.
// Each cell compares its entry against the item in parallel; a priority
// pick chooses the first fitting (or matching) cell, and in the cycle after
// the pick the row shifts up by one (split) or down by one (merge) in a single step.
// The item passes through the pick and update states, and done is registered
// from the update state; busy stays high through the done cycle, so no new
// item is accepted before the previous result has been given.
// done is high for exactly one cycle with result_addr and status; the
// receiver cannot stall the result.
// Reset: the table holds one free block spanning the heap less a header,
// entry count one; no clearing pass is needed.
module first_fit_heap_allocator_core
    import ffha_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        op,
    input  logic [20:0] req_size,
    input  logic [19:0] payload_addr,
    output logic        done,
    output logic [19:0] result_addr,
    output logic [1:0]  status
);
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_PICK = 2'd1;
    localparam logic [1:0] S_UPD  = 2'd2;

    logic [1:0] state_reg, state_next;
    logic op_reg;
    logic [20:0] size_reg;
    logic [19:0] addr_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    logic found_reg, found_next;
    logic [IDX_W-1:0] sel_reg, sel_next;
    logic done_reg;
    logic [19:0] raddr_reg;
    logic [1:0] status_reg;

    entry_t ent [MAX_BLOCKS];
    logic [MAX_BLOCKS-1:0] fit, hit;
    cmd_t cmd;

    // cell row
    for (genvar g = 0; g < MAX_BLOCKS; g++)
    begin : g_cell
        entry_t left_e, right_e;
        if (g == 0)
        begin : g_l0
            assign left_e = '0;
        end
        else
        begin : g_l
            assign left_e = ent[g-1];
        end
        if (g == MAX_BLOCKS - 1)
        begin : g_rn
            assign right_e = '0;
        end
        else
        begin : g_r
            assign right_e = ent[g+1];
        end
        ffha_cell u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .my_idx       (IDX_W'(g)),
            .reset_free   (g == 0),
            .reset_payload(g == 0 ? INIT_PAY : 20'd0),
            .cmd          (cmd),
            .left_in      (left_e),
            .right_in     (right_e),
            .top_valid    (CNT_W'(g + 1) < count_reg),
            .entry        (ent[g]),
            .req_size     (size_reg),
            .addr         (addr_reg),
            .fit          (fit[g]),
            .hit          (hit[g])
        );
    end

    // first-fit / first-match priority pick over valid cells
    always_comb
    begin
        found_next = 1'b0;
        sel_next = '0;
        for (int i = MAX_BLOCKS - 1; i >= 0; i--)
        begin
            if (CNT_W'(i) < count_reg &&
                ((op_reg == OP_ALLOC) ? fit[i] : hit[i]))
            begin
                found_next = 1'b1;
                sel_next = IDX_W'(i);
            end
        end
    end

    // table update command
    entry_t se, ne;
    logic [20:0] need;
    logic do_split, do_merge;
    always_comb
    begin
        se = ent[sel_reg];
        ne = (sel_reg == IDX_W'(MAX_BLOCKS - 1)) ? '0 : ent[sel_reg + IDX_W'(1)];
        need = size_reg + 21'(HEADER_BYTES);
        do_split = (op_reg == OP_ALLOC) && ({1'b0, se.payload} > need) &&
                   (count_reg < CNT_W'(MAX_BLOCKS));
        do_merge = (op_reg == OP_FREE) &&
                   (CNT_W'(sel_reg) + CNT_W'(1) < count_reg) && ne.is_free;
        cmd = '0;
        cmd.sel = sel_reg;
        if (state_reg == S_UPD && found_reg && !(op_reg == OP_FREE && addr_reg == 20'd0))
        begin
            cmd.write_sel = 1'b1;
            cmd.wr_entry = se;
            if (op_reg == OP_ALLOC)
            begin
                cmd.wr_entry.is_free = 1'b0;
                if (do_split)
                begin
                    cmd.wr_entry.payload = size_reg[19:0];
                    cmd.shift_up = 1'b1;
                    cmd.write_next = 1'b1;
                    cmd.nx_entry.start = se.start + HDR20 + size_reg[19:0];
                    cmd.nx_entry.payload = se.payload - size_reg[19:0] - HDR20;
                    cmd.nx_entry.is_free = 1'b1;
                end
            end
            else
            begin
                cmd.wr_entry.is_free = 1'b1;
                if (do_merge)
                begin
                    cmd.wr_entry.payload = se.payload + HDR20 + ne.payload;
                    cmd.shift_down = 1'b1;
                end
            end
        end
    end

    // control sequencer
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        unique case (state_reg)
            S_IDLE: if (start && !done_reg) state_next = S_PICK;
            S_PICK: state_next = S_UPD;
            S_UPD:
            begin
                state_next = S_IDLE;
                if (cmd.shift_up)
                    count_next = count_reg + CNT_W'(1);
                else if (cmd.shift_down)
                    count_next = count_reg - CNT_W'(1);
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= CNT_W'(1);
            done_reg <= 1'b0;
            found_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg <= (state_reg == S_UPD);
            if (state_reg == S_PICK)
                found_reg <= found_next;
        end
    end

    // item capture, selection and result registers
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && start && !done_reg)
        begin
            op_reg <= op;
            size_reg <= req_size;
            addr_reg <= payload_addr;
        end
        if (state_reg == S_PICK)
            sel_reg <= sel_next;
        if (state_reg == S_UPD)
        begin
            raddr_reg <= 20'd0;
            status_reg <= ST_OK;
            if (op_reg == OP_ALLOC)
            begin
                if (found_reg)
                    raddr_reg <= se.start + HDR20;
                else
                    status_reg <= ST_NOFIT;
            end
            else if (addr_reg != 20'd0 && !found_reg)
                status_reg <= ST_BADFREE;
        end
    end

    assign busy = (state_reg != S_IDLE) || done_reg;
    assign done = done_reg;
    assign result_addr = raddr_reg;
    assign status = status_reg;

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg >= CNT_W'(1) && count_reg <= CNT_W'(MAX_BLOCKS))
        else $error("block count out of range");
    a_done_after_upd: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg) == S_UPD)
        else $error("done without update");
    a_nofit_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && status != ST_OK |-> result_addr == 20'd0)
        else $error("address on failure");
`endif
endmodule

@@ tb/first_fit_heap_allocator_core_tb.sv @@
`timescale 1ns / 1ps

module first_fit_heap_allocator_core_tb;
    import ffha_pkg::*;

    typedef struct {
        logic        op;
        logic [20:0] size;
        logic [19:0] addr;
    } req_t;

    typedef struct {
        logic [19:0] addr;
        logic [1:0]  status;
    } resp_t;

    localparam int WATCHDOG_LIMIT = 2000;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic        op;
    logic [20:0] req_size;
    logic [19:0] payload_addr;
    logic        done;
    logic [19:0] result_addr;
    logic [1:0]  status;

    // shadow copy of the block table
    logic [19:0] heap_start [MAX_BLOCKS];
    logic [19:0] heap_pay   [MAX_BLOCKS];
    logic        heap_free  [MAX_BLOCKS];
    int          heap_cnt;

    req_t  pending_reqs [$];
    resp_t expected_resps [$];
    int    fail_count;
    int    idle_cycles;
    int    burst_left;
    int    gap_left;
    bit    stim_done;

    first_fit_heap_allocator_core DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .op           (op),
        .req_size     (req_size),
        .payload_addr (payload_addr),
        .done         (done),
        .result_addr  (result_addr),
        .status       (status)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    task automatic heap_reset();
        for (int i = 0; i < MAX_BLOCKS; i++)
        begin
            heap_start[i] = '0;
            heap_pay[i]   = '0;
            heap_free[i]  = 1'b0;
        end
        heap_pay[0]  = INIT_PAY;
        heap_free[0] = 1'b1;
        heap_cnt     = 1;
    endtask

    // first-fit allocate / free with next-block merge
    function automatic resp_t heap_apply(req_t r);
        resp_t res;
        logic [31:0] sz;
        res.addr   = '0;
        res.status = ST_OK;
        sz = 32'(r.size);
        if (r.op == OP_ALLOC)
        begin
            res.status = ST_NOFIT;
            for (int i = 0; i < heap_cnt; i++)
            begin
                if (heap_free[i] && 32'(heap_pay[i]) >= sz)
                begin
                    if (32'(heap_pay[i]) > sz + HEADER_BYTES && heap_cnt < MAX_BLOCKS)
                    begin
                        for (int j = heap_cnt; j > i + 1; j--)
                        begin
                            heap_start[j] = heap_start[j-1];
                            heap_pay[j]   = heap_pay[j-1];
                            heap_free[j]  = heap_free[j-1];
                        end
                        heap_start[i+1] = 20'(32'(heap_start[i]) + HEADER_BYTES + sz);
                        heap_pay[i+1]   = 20'(32'(heap_pay[i]) - sz - HEADER_BYTES);
                        heap_free[i+1]  = 1'b1;
                        heap_pay[i]     = 20'(sz);
                        heap_cnt++;
                    end
                    heap_free[i] = 1'b0;
                    res.addr     = heap_start[i] + HDR20;
                    res.status   = ST_OK;
                    break;
                end
            end
        end
        else if (r.addr != '0)
        begin
            res.status = ST_BADFREE;
            for (int i = 0; i < heap_cnt; i++)
            begin
                if (32'(heap_start[i]) + HEADER_BYTES == 32'(r.addr))
                begin
                    res.status   = ST_OK;
                    heap_free[i] = 1'b1;
                    if (i + 1 < heap_cnt && heap_free[i+1])
                    begin
                        heap_pay[i] = heap_pay[i] + HDR20 + heap_pay[i+1];
                        for (int j = i + 1; j + 1 < heap_cnt; j++)
                        begin
                            heap_start[j] = heap_start[j+1];
                            heap_pay[j]   = heap_pay[j+1];
                            heap_free[j]  = heap_free[j+1];
                        end
                        heap_cnt--;
                        heap_start[heap_cnt] = '0;
                        heap_pay[heap_cnt]   = '0;
                        heap_free[heap_cnt]  = 1'b0;
                    end
                    break;
                end
            end
        end
        return res;
    endfunction

    function automatic req_t mk_alloc(int unsigned sz);
        req_t r;
        r.op   = OP_ALLOC;
        r.size = 21'(sz);
        r.addr = 20'($urandom);
        return r;
    endfunction

    function automatic req_t mk_free(logic [19:0] a);
        req_t r;
        r.op   = OP_FREE;
        r.size = 21'($urandom);
        r.addr = a;
        return r;
    endfunction

    function automatic int unsigned rand_size();
        int unsigned k;
        k = $urandom_range(0, 99);
        if (k < 50)
            return $urandom_range(0, 64);
        else if (k < 85)
            return $urandom_range(0, 4096);
        else if (k < 97)
            return $urandom_range(0, 65536);
        else
            return $urandom_range(0, 1 << 20);
    endfunction

    // fill the item queue
    initial
    begin
        int   k;
        stim_done = 1'b0;
        // directed: extremes, null, unknown and double free, full table
        pending_reqs.push_back(mk_alloc(1 << 20));
        pending_reqs.push_back(mk_alloc(0));
        pending_reqs.push_back(mk_free(20'd16));
        pending_reqs.push_back(mk_free(20'd16));
        pending_reqs.push_back(mk_free(20'd0));
        pending_reqs.push_back(mk_free(20'hFFFFF));
        pending_reqs.push_back(mk_free(20'd17));
        pending_reqs.push_back(mk_alloc(HEAP_BYTES - HEADER_BYTES));
        pending_reqs.push_back(mk_free(20'd16));
        pending_reqs.push_back(mk_alloc(21'h1FFFFF));
        pending_reqs.push_back(mk_alloc(HEAP_BYTES - HEADER_BYTES - 20));
        pending_reqs.push_back(mk_free(20'd16));
        for (int i = 0; i < 70; i++)
            pending_reqs.push_back(mk_alloc(i % 3));
        for (int i = 0; i < 1880; i++)
        begin
            k = $urandom_range(0, 99);
            if (k < 45)
                pending_reqs.push_back(mk_alloc(rand_size()));
            else if (k < 88)
                pending_reqs.push_back(mk_free(20'($urandom_range(0, 255)) * 20'd16 + 20'd16));
            else if (k < 93)
                pending_reqs.push_back(mk_free(20'd0));
            else
                pending_reqs.push_back(mk_free(20'($urandom)));
        end
        // long run of frees and a full-size allocate
        for (int i = 0; i < 64; i++)
            pending_reqs.push_back(mk_free(20'd16 + 20'(i) * 20'd17));
        pending_reqs.push_back(mk_alloc(HEAP_BYTES - HEADER_BYTES));
        stim_done = 1'b1;
    end

    // reset and initial drive
    initial
    begin
        fail_count   = 0;
        rst_n        = 1'b0;
        start        = 1'b0;
        op           = 1'b0;
        req_size     = '0;
        payload_addr = '0;
        heap_reset();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
    end

    // driver: bursts of items separated by random gaps
    initial
    begin
        burst_left = 0;
        gap_left   = 0;
    end

    always @(posedge clk)
    begin
        req_t r;
        if (rst_n)
        begin
            if (start && !busy)
            begin
                r.op   = op;
                r.size = req_size;
                r.addr = payload_addr;
                expected_resps.push_back(heap_apply(r));
            end
            if (start && busy)
            begin
                // hold the item until accepted
            end
            else if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                start    <= 1'b0;
            end
            else if (pending_reqs.size() > 0)
            begin
                r = pending_reqs.pop_front();
                start        <= 1'b1;
                op           <= r.op;
                req_size     <= r.size;
                payload_addr <= r.addr;
                if (burst_left > 0)
                    burst_left <= burst_left - 1;
                else
                begin
                    burst_left <= $urandom_range(0, 30);
                    gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
                end
            end
            else
                start <= 1'b0;
        end
    end

    // monitor: compare each done strobe against the oldest expectation
    always @(posedge clk)
    begin
        resp_t e;
        if (rst_n && done)
        begin
            if (expected_resps.size() == 0)
            begin
                $error("unexpected result addr=%0h status=%0d", result_addr, status);
                fail_count++;
            end
            else
            begin
                e = expected_resps.pop_front();
                if (result_addr !== e.addr)
                begin
                    $error("result_addr expected %0h actual %0h", e.addr, result_addr);
                    fail_count++;
                end
                if (status !== e.status)
                begin
                    $error("status expected %0d actual %0d", e.status, status);
                    fail_count++;
                end
            end
        end
    end

    // watchdog and end of run
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        idle_cycles = 0;
        wait (rst_n === 1'b1);
        fork
            begin
                wait (stim_done && pending_reqs.size() == 0 && !start
                      && expected_resps.size() == 0);
                repeat (10) @(posedge clk);
            end
            begin
                wait (idle_cycles >= WATCHDOG_LIMIT);
                fail_count++;
                $display("watchdog timeout");
            end
        join_any
        if (fail_count == 0 && expected_resps.size() == 0)
            $display("first_fit_heap_allocator_core_tb OK");
        else
            $display("first_fit_heap_allocator_core_tb NOT OK");
        $finish;
    end
endmodule

@@ filelist.f @@
design/ffha_pkg.sv
design/ffha_cell.sv
design/first_fit_heap_allocator_core.sv
tb/first_fit_heap_allocator_core_tb.sv
